[hdl/ddrc_pkg.sv]
`timescale 1ns / 1ps

package ddrc_pkg;

	// Input item kinds
	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_START      = 3'd1,
		CMD_STOP       = 3'd2,
		CMD_TEST_RIGHT = 3'd3,
		CMD_TEST_LEFT  = 3'd4,
		CMD_ESTOP      = 3'd5
	} cmd_t;

	// Operating modes as reported on the result beat
	typedef enum logic [2:0] {
		MODE_STANDBY    = 3'd0,
		MODE_RAMP_UP    = 3'd1,
		MODE_RUN        = 3'd2,
		MODE_RAMP_DOWN  = 3'd3,
		MODE_TEST_RIGHT = 3'd4,
		MODE_TEST_LEFT  = 3'd5
	} mode_t;

	// Latched pending event
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_START      = 3'd1,
		EV_STOP       = 3'd2,
		EV_TEST_RIGHT = 3'd3,
		EV_TEST_LEFT  = 3'd4
	} event_t;

	// Test sequence phase
	typedef enum logic [1:0] {
		PH_UP   = 2'd0,
		PH_HOLD = 2'd1,
		PH_DOWN = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	// Operations of the shared scale unit
	typedef enum logic [1:0] {
		OP_STEER = 2'd0,
		OP_FEED  = 2'd1,
		OP_LEFT  = 2'd2,
		OP_RIGHT = 2'd3
	} op_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEER,
		ST_STEER_W,
		ST_FEED,
		ST_FEED_W,
		ST_LEFT,
		ST_RIGHT,
		ST_DRAIN,
		ST_DONE
	} ctrl_state_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BALANCE_TRIM = 2'd0,
		REG_FULL_SPEED   = 2'd1,
		REG_STEP_TICKS   = 2'd2
	} reg_idx_t;

	// Sequencer constants
	localparam logic [10:0] TEST_PEAK   = 11'd512;
	localparam logic [9:0]  HOLD_TICKS  = 10'd1000;
	localparam int          STEER_SPAN  = 170;
	localparam logic [10:0] MAX_LEVEL   = 11'd1024;
	localparam logic [6:0]  PCT_FULL    = 7'd100;
	localparam logic [7:0]  TRIM_LIMIT  = 8'sd100;

	// Division by constants as multiply by rounded-up reciprocal
	localparam int          SCALE_SHIFT = 26;
	localparam logic [26:0] RECIP_PCT   = 27'((2**SCALE_SHIFT + 100 - 1) / 100);
	localparam logic [26:0] RECIP_SPAN  =
		27'((2**SCALE_SHIFT + STEER_SPAN - 1) / STEER_SPAN);

	// Controller to datapath
	typedef struct packed {
		logic apply;     // accepted beat: update sequencer state
		logic issue;     // start a scale operation
		op_t  op;
		logic load_out;  // capture result beat
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic plan_run;    // combinational, valid with apply
		logic plan_left;
		logic plan_right;
		logic right_q;     // registered: right motor still to drive
	} dp_stat_t;

endpackage

[hdl/ddrc_ctrl.sv]
`timescale 1ns / 1ps

module ddrc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ddrc_pkg::dp_stat_t stat,
	output ddrc_pkg::dp_cmd_t  cmd
);
	import ddrc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        in_fire;
	logic        slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (stat.plan_run) state_d = ST_STEER;
					else if (stat.plan_left) state_d = ST_LEFT;
					else if (stat.plan_right) state_d = ST_RIGHT;
					else state_d = ST_DONE;
				end
			end
			ST_STEER:   state_d = ST_STEER_W;
			ST_STEER_W: state_d = ST_FEED;
			ST_FEED:    state_d = ST_FEED_W;
			ST_FEED_W:  state_d = ST_LEFT;
			ST_LEFT:    state_d = stat.right_q ? ST_RIGHT : ST_DRAIN;
			ST_RIGHT:   state_d = ST_DRAIN;
			ST_DRAIN:   state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs to datapath
	always_comb begin
		cmd = '0;
		cmd.op = OP_STEER;
		unique case (state_q)
			ST_IDLE:  cmd.apply = in_fire;
			ST_STEER: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_STEER;
			end
			ST_FEED: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_FEED;
			end
			ST_LEFT: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_LEFT;
			end
			ST_RIGHT: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_RIGHT;
			end
			ST_DONE:  cmd.load_out = slot_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken again before result produced");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result beat overwritten");

	a_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && slot_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished item not presented");

endmodule

[hdl/ddrc_dp.sv]
`timescale 1ns / 1ps

module ddrc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         command,
	input  logic signed [7:0]  line_angle,
	input  logic signed [7:0]  line_offset,
	input  logic signed [7:0]  balance_trim,
	input  logic [10:0]        full_speed,
	input  logic [15:0]        step_ticks,
	input  ddrc_pkg::dp_cmd_t  cmd,
	output ddrc_pkg::dp_stat_t stat,
	output logic [31:0]        out_data
);
	import ddrc_pkg::*;

	// Sequencer state
	mode_t       mode_q, mode_d;
	event_t      pend_q, pend_d;
	logic [10:0] ramp_q, ramp_d;
	logic [15:0] wait_q, wait_d;
	phase_t      phase_q, phase_d;
	logic [9:0]  hold_q, hold_d, hold_inc;
	logic [10:0] left_out_q, right_out_q;
	logic        zero_out;
	logic        drive, do_down;
	logic        plan_run;
	logic        drv_right_q;
	logic [10:0] target;

	// Operands of the current item
	logic signed [8:0] sum_q;
	logic [6:0]        s_mag_q;
	logic [10:0]       lfeed_q, rfeed_q;

	// Scale unit
	logic              valid_s1;
	op_t               op_s1;
	logic [16:0]       prod_s1;
	logic [26:0]       recip_s1;
	logic [10:0]       sc_x;
	logic [6:0]        sc_f;
	logic [26:0]       sc_recip;
	logic [17:0]       prod_full;
	logic [43:0]       quo_full;
	logic [17:0]       quo;
	logic [8:0]        abs_sum;

	// Trim factors
	logic signed [7:0] bsat;
	logic signed [8:0] lsum, rsum;
	logic [6:0]        lfac, rfac;

	// Result beat register
	logic [10:0] out_left_q, out_right_q;
	logic [2:0]  out_mode_q;

	assign target = (full_speed > MAX_LEVEL) ? MAX_LEVEL : full_speed;

	// Balance trim factors, trim saturated to +/-100
	always_comb begin
		if (balance_trim > $signed(TRIM_LIMIT)) bsat = $signed(TRIM_LIMIT);
		else if (balance_trim < -$signed(TRIM_LIMIT)) bsat = -$signed(TRIM_LIMIT);
		else bsat = balance_trim;
		lsum = 9'sd100 + {bsat[7], bsat};
		rsum = 9'sd100 - {bsat[7], bsat};
		lfac = bsat[7] ? lsum[6:0] : PCT_FULL;
		rfac = (bsat > 8'sd0) ? rsum[6:0] : PCT_FULL;
	end

	// Sequencer step for one accepted beat
	always_comb begin
		mode_d   = mode_q;
		pend_d   = pend_q;
		ramp_d   = ramp_q;
		wait_d   = wait_q;
		phase_d  = phase_q;
		hold_d   = hold_q;
		hold_inc = hold_q + 10'd1;
		zero_out = 1'b0;
		drive    = 1'b0;
		do_down  = 1'b0;
		plan_run = 1'b0;
		unique case (command) inside
			CMD_TICK: begin
				unique case (mode_q)
					MODE_STANDBY: begin
						if (pend_q inside {EV_START, EV_TEST_RIGHT, EV_TEST_LEFT}) begin
							if (pend_q == EV_START) mode_d = MODE_RAMP_UP;
							else if (pend_q == EV_TEST_RIGHT) mode_d = MODE_TEST_RIGHT;
							else mode_d = MODE_TEST_LEFT;
							pend_d  = EV_NONE;
							ramp_d  = '0;
							wait_d  = '0;
							phase_d = PH_UP;
							hold_d  = '0;
						end
					end
					MODE_RAMP_UP: begin
						if (wait_q != '0) begin
							wait_d = wait_q - 16'd1;
						end else if (ramp_q < target) begin
							drive  = 1'b1;
							ramp_d = ramp_q + 11'd1;
							wait_d = step_ticks;
						end else begin
							mode_d = MODE_RUN;
							pend_d = EV_NONE;
						end
					end
					MODE_RUN: begin
						drive    = 1'b1;
						plan_run = 1'b1;
						if (pend_q == EV_STOP) begin
							mode_d  = MODE_RAMP_DOWN;
							pend_d  = EV_NONE;
							ramp_d  = target;
							wait_d  = '0;
							phase_d = PH_UP;
						end
					end
					MODE_RAMP_DOWN: begin
						if (wait_q != '0) wait_d = wait_q - 16'd1;
						else do_down = 1'b1;
					end
					MODE_TEST_RIGHT, MODE_TEST_LEFT: begin
						if (phase_q == PH_HOLD) begin
							hold_d = hold_inc;
							if (hold_inc >= HOLD_TICKS) begin
								phase_d = PH_DOWN;
								ramp_d  = TEST_PEAK;
								wait_d  = '0;
							end
						end else if (wait_q != '0) begin
							wait_d = wait_q - 16'd1;
						end else if (phase_q == PH_UP) begin
							if (ramp_q < TEST_PEAK) begin
								drive  = 1'b1;
								ramp_d = ramp_q + 11'd1;
								wait_d = step_ticks;
							end else begin
								phase_d = PH_HOLD;
								hold_d  = '0;
							end
						end else begin
							do_down = 1'b1;
						end
					end
					default: begin
						mode_d  = MODE_STANDBY;
						pend_d  = EV_NONE;
						wait_d  = '0;
						phase_d = PH_UP;
						hold_d  = '0;
					end
				endcase
				// shared ramp-down step
				if (do_down) begin
					if (phase_q == PH_DONE) begin
						mode_d  = MODE_STANDBY;
						pend_d  = EV_NONE;
						wait_d  = '0;
						phase_d = PH_UP;
						hold_d  = '0;
					end else begin
						drive = 1'b1;
						if (ramp_q == '0) phase_d = PH_DONE;
						else ramp_d = ramp_q - 11'd1;
						wait_d = step_ticks;
					end
				end
			end
			CMD_START, CMD_STOP, CMD_TEST_RIGHT, CMD_TEST_LEFT: begin
				pend_d = event_t'(command);
			end
			CMD_ESTOP: begin
				mode_d   = MODE_STANDBY;
				pend_d   = EV_NONE;
				wait_d   = '0;
				phase_d  = PH_UP;
				hold_d   = '0;
				ramp_d   = '0;
				zero_out = 1'b1;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
	end

	assign stat.plan_run   = plan_run;
	assign stat.plan_left  = drive && (mode_q != MODE_TEST_RIGHT);
	assign stat.plan_right = drive && (mode_q != MODE_TEST_LEFT);
	assign stat.right_q    = drv_right_q;

	// Scale unit operand select: x * f / divisor
	always_comb begin
		abs_sum = sum_q[8] ? 9'(-sum_q) : 9'(sum_q);
		sc_recip = RECIP_PCT;
		case (cmd.op)
			OP_STEER: begin
				sc_x     = {2'b00, abs_sum};
				sc_f     = PCT_FULL;
				sc_recip = RECIP_SPAN;
			end
			OP_FEED: begin
				sc_x = sum_q[8] ? lfeed_q : rfeed_q;
				sc_f = PCT_FULL - s_mag_q;
			end
			OP_LEFT: begin
				sc_x = lfeed_q;
				sc_f = lfac;
			end
			default: begin
				sc_x = rfeed_q;
				sc_f = rfac;
			end
		endcase
		prod_full = {7'd0, sc_x} * {11'd0, sc_f};
	end

	// Second stage: reciprocal multiply and shift
	assign quo_full = {27'd0, prod_s1} * {17'd0, recip_s1};
	assign quo      = quo_full[43:SCALE_SHIFT];

	// Control and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STANDBY;
			pend_q      <= EV_NONE;
			ramp_q      <= '0;
			wait_q      <= '0;
			phase_q     <= PH_UP;
			hold_q      <= '0;
			left_out_q  <= '0;
			right_out_q <= '0;
			drv_right_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.apply) begin
				mode_q      <= mode_d;
				pend_q      <= pend_d;
				ramp_q      <= ramp_d;
				wait_q      <= wait_d;
				phase_q     <= phase_d;
				hold_q      <= hold_d;
				drv_right_q <= stat.plan_right;
				if (zero_out) begin
					left_out_q  <= '0;
					right_out_q <= '0;
				end
			end else if (valid_s1 && op_s1 == OP_LEFT) begin
				left_out_q <= quo[10:0];
			end else if (valid_s1 && op_s1 == OP_RIGHT) begin
				right_out_q <= quo[10:0];
			end
		end
	end

	// Item operands and scale pipeline payload
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			op_s1    <= cmd.op;
			prod_s1  <= prod_full[16:0];
			recip_s1 <= sc_recip;
		end
		if (cmd.apply) begin
			sum_q   <= {line_offset[7], line_offset} + {line_angle[7], line_angle};
			lfeed_q <= ramp_q;
			rfeed_q <= ramp_q;
		end else if (valid_s1 && op_s1 == OP_STEER) begin
			s_mag_q <= (quo > 18'd100) ? PCT_FULL : quo[6:0];
		end else if (valid_s1 && op_s1 == OP_FEED) begin
			if (sum_q[8]) lfeed_q <= quo[10:0];
			else rfeed_q <= quo[10:0];
		end
		if (cmd.load_out) begin
			out_left_q  <= left_out_q;
			out_right_q <= right_out_q;
			out_mode_q  <= mode_q;
		end
	end

	assign out_data = {7'd0, out_mode_q, out_right_q, out_left_q};

	a_ramp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q <= MAX_LEVEL)
		else $error("ramp level above full scale");

	a_hold_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q <= HOLD_TICKS)
		else $error("hold counter overran");

	a_estop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && command == CMD_ESTOP) |=>
		(mode_q == MODE_STANDBY && left_out_q == '0 && right_out_q == '0 && ramp_q == '0))
		else $error("emergency stop did not clear outputs");

endmodule

[hdl/differential_drive_ramp_controller_top.sv]
`timescale 1ns / 1ps

// Two-motor PWM sequencer with soft-start and soft-stop ramps, line steering
// in run mode and a single-motor test. Each input beat is a millisecond tick
// or a command (tuser) and yields exactly one result beat with both motor
// levels and the mode after the beat. Commands and ticks that drive nothing
// go straight to the result; a ramp tick drives the left and then the right
// motor, a test-ramp tick one motor, and a run tick steers before both. All
// scaling goes through one two-stage multiply-by-reciprocal unit that is
// used once for the steering value, once for the steered side and once per
// motor for the balance trim. One item is in flight at a time; the result
// register lets the next item be accepted while a result beat waits.
// Configuration (APB, registers at 0x0 balance_trim, 0x4 full_speed,
// 0x8 step_ticks) is to be written only while the block is idle.
module differential_drive_ramp_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] line_angle, [15:8] line_offset
	input  logic [2:0]  s_axis_tuser,  // [2:0] command
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [10:0] left_level, [21:11] right_level,
	                                   // [24:22] mode, rest zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ddrc_pkg::*;

	logic signed [7:0] balance_trim_q;
	logic [10:0]       full_speed_q;
	logic [15:0]       step_ticks_q;
	logic              cfg_write;
	dp_cmd_t           dp_cmd;
	dp_stat_t          dp_stat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_trim_q <= '0;
			full_speed_q   <= MAX_LEVEL;
			step_ticks_q   <= '0;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_BALANCE_TRIM: balance_trim_q <= pwdata[7:0];
				REG_FULL_SPEED:   full_speed_q   <= pwdata[10:0];
				REG_STEP_TICKS:   step_ticks_q   <= pwdata[15:0];
				default:          step_ticks_q   <= step_ticks_q;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_BALANCE_TRIM: prdata = {24'd0, balance_trim_q};
			REG_FULL_SPEED:   prdata = {21'd0, full_speed_q};
			REG_STEP_TICKS:   prdata = {16'd0, step_ticks_q};
			default:          prdata = '0;
		endcase
	end

	ddrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	ddrc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (s_axis_tuser),
		.line_angle   (s_axis_tdata[7:0]),
		.line_offset  (s_axis_tdata[15:8]),
		.balance_trim (balance_trim_q),
		.full_speed   (full_speed_q),
		.step_ticks   (step_ticks_q),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.out_data     (m_axis_tdata)
	);

endmodule
